/* hw/rtl/srtc_pkg.sv */
// shared constants and types for the serial rtc / nvram interface
// no dependencies; imported by srtc_nvram, srtc_core and the top level
package srtc_pkg;

   localparam int BANK_BYTES = 32;
   localparam int MEM_DEPTH  = 2 * BANK_BYTES;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int BANK_AW    = $clog2(BANK_BYTES);

   // transfer bit counter: 1..8 address, 9..16 data
   localparam logic [4:0] PHASE_ADDR_END = 5'd8;
   localparam logic [4:0] PHASE_DATA_GO  = 5'd9;
   localparam logic [4:0] PHASE_DATA_END = 5'd16;

   // clock register addresses, bit 7 stripped
   localparam logic [6:0] CLK_TIME3   = 7'h20;
   localparam logic [6:0] CLK_TIME2   = 7'h21;
   localparam logic [6:0] CLK_TIME1   = 7'h22;
   localparam logic [6:0] CLK_TIME0   = 7'h23;
   localparam logic [6:0] CLK_STATUS  = 7'h30;
   localparam logic [6:0] CLK_CONTROL = 7'h31;

   localparam logic [7:0] STATUS_READ_SET = 8'h80;
   localparam logic [7:0] STATUS_PWR_DOWN = 8'h09;
   localparam logic [7:0] CONTROL_MASK    = 8'h0D;

   typedef enum logic [1:0] {
      MODE_BIT   = 2'd0,
      MODE_RESET = 2'd1,
      MODE_POWER = 2'd2
   } mode_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [MEM_AW-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic halt_request;
      logic data_out;
   } result_type;

endpackage

/* hw/rtl/srtc_nvram.sv */
// 64-byte nvram array with per-entry valid bits and registered read data
// depends on srtc_pkg
module srtc_nvram (
   input  logic                 clock,
   input  logic                 reset,
   input  srtc_pkg::mem_req_type mem_req,
   output logic [7:0]           rd_data
);
   import srtc_pkg::*;

   logic [7:0]           nv_mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         nv_mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= nv_mem_ff[mem_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_req.we) begin
            vld_ff[mem_req.waddr] <= 1'b1;
         end
         if (mem_req.re) begin
            rd_vld_ff <= vld_ff[mem_req.raddr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : 8'h00;

endmodule

/* hw/rtl/srtc_core.sv */
// transfer state: bit counter, address and data shifters, status and control
// depends on srtc_pkg; drives the nvram port of srtc_nvram
module srtc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 acc,
   input  srtc_pkg::mode_type   mode,
   input  logic                 data_bit,
   input  logic [31:0]          time_now,
   input  logic [7:0]           mem_rdata,
   output srtc_pkg::mem_req_type mem_req,
   output srtc_pkg::result_type result
);
   import srtc_pkg::*;

   logic [4:0] phase_ff, phase_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] dshift_ff, dshift_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] control_ff, control_in;

   logic [4:0] phase_nx;
   logic [4:0] phase_dat;
   logic       wr;
   logic [7:0] rd_byte;
   logic [7:0] byte_cur;
   logic [7:0] byte_nx;
   logic [2:0] bit_sel;

   function automatic logic [MEM_AW-1:0] mem_index(input logic [7:0] a);
      return {a[6], a[BANK_AW-1:0]};
   endfunction

   function automatic logic [7:0] clock_read(input logic [7:0] a, input logic [31:0] t,
                                             input logic [7:0] st, input logic [7:0] ct);
      logic [7:0] v;
      case (a[6:0])
         CLK_TIME3:   v = t[31:24];
         CLK_TIME2:   v = t[23:16];
         CLK_TIME1:   v = t[15:8];
         CLK_TIME0:   v = t[7:0];
         CLK_STATUS:  v = st | STATUS_READ_SET;
         CLK_CONTROL: v = ct & ~CONTROL_MASK;
         default:     v = 8'h00;
      endcase
      return v;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      addr_in    = addr_ff;
      dshift_in  = dshift_ff;
      status_in  = status_ff;
      control_in = control_ff;
      result     = '0;
      mem_req.we    = 1'b0;
      mem_req.waddr = mem_index(addr_ff);
      mem_req.wdata = 8'h00;
      wr        = addr_ff[7];
      phase_nx  = phase_ff + 5'd1;
      phase_dat = (phase_nx > PHASE_DATA_END) ? PHASE_DATA_END : phase_nx;
      rd_byte   = addr_ff[5] ? clock_read(addr_ff, time_now, status_ff, control_ff)
                             : mem_rdata;
      byte_cur  = (phase_dat == PHASE_DATA_GO && !wr) ? rd_byte : dshift_ff;
      byte_nx   = wr ? {byte_cur[6:0], data_bit} : byte_cur;
      bit_sel   = 3'(PHASE_DATA_END - phase_dat);
      if (acc) begin
         case (mode)
            MODE_RESET: begin
               phase_in  = '0;
               addr_in   = '0;
               dshift_in = '0;
            end
            MODE_POWER: begin
               status_in = status_ff | STATUS_PWR_DOWN;
            end
            MODE_BIT: begin
               result.data_out = data_bit;
               if (phase_nx <= PHASE_ADDR_END) begin
                  addr_in  = {addr_ff[6:0], data_bit};
                  phase_in = phase_nx;
               end else begin
                  if (!wr) begin
                     result.data_out = byte_cur[bit_sel];
                  end
                  dshift_in = byte_nx;
                  phase_in  = phase_dat;
                  if (phase_dat == PHASE_DATA_END) begin
                     if (wr && addr_ff[5]) begin
                        if (addr_ff[6:0] == CLK_CONTROL) begin
                           control_in = byte_nx;
                           status_in  = status_ff & ~{3'b000, byte_nx[2], 2'b00,
                                                      byte_nx[3], byte_nx[0]};
                           result.halt_request = byte_nx[6];
                        end
                     end else if (wr) begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = byte_nx;
                     end
                     // wrap within each half of the address space
                     addr_in  = {addr_ff[7], addr_ff[6:0] + 7'd1};
                     phase_in = PHASE_ADDR_END;
                  end
               end
            end
            default: ;
         endcase
      end
      // prefetch the byte at the next address so it is ready at data start
      mem_req.re    = acc;
      mem_req.raddr = mem_index(addr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         addr_ff    <= '0;
         dshift_ff  <= '0;
         status_ff  <= '0;
         control_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         addr_ff    <= addr_in;
         dshift_ff  <= dshift_in;
         status_ff  <= status_in;
         control_ff <= control_in;
      end
   end

endmodule

/* hw/rtl/serial_rtc_nvram_counter_interface.sv */
// top level of the serial rtc / nvram interface: handshakes and result register
// depends on srtc_pkg, srtc_nvram and srtc_core
//
//   channel   ports                       carries
//   request   req_tvalid/tready/tdata/tuser  serial bit, time, mode
//   response  rsp_tvalid/tready/tdata     echoed or read bit, halt request
//
// one request per cycle while no stalled response holds; its response is valid in the cycle after acceptance.
// nvram reads are prefetched from the next address at every accepted request.
// reset clears the transfer state and the nvram valid bits.
// a stalled response holds in its register; a request is still taken if the
// response is being taken in the same cycle.
module serial_rtc_nvram_counter_interface (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_bit [0], time_now [32:1], zero fill
   input  logic [1:0]  req_tuser,   // mode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // data_out [0], halt_request [1], zero fill
);
   import srtc_pkg::*;

   logic        in_acc;
   mem_req_type mem_req;
   logic [7:0]  mem_rdata;
   result_type  result;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign in_acc     = req_tvalid && req_tready;

   srtc_nvram u_nvram (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   srtc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .acc       (in_acc),
      .mode      (mode_type'(req_tuser)),
      .data_bit  (req_tdata[0]),
      .time_now  (req_tdata[32:1]),
      .mem_rdata (mem_rdata),
      .mem_req   (mem_req),
      .result    (result)
   );

   assign rsp_valid_in = in_acc || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_data_ff};

`ifndef SYNTHESIS
   // a reset, power-down or unused-mode request returns an all-zero response
   assert property (@(posedge clock) disable iff (reset)
      in_acc && req_tuser != MODE_BIT |=> rsp_tdata[1:0] == 2'b00)
      else $error("non-bit request gave a nonzero response");

   assert property (@(posedge clock) disable iff (reset)
      in_acc |=> rsp_tvalid)
      else $error("accepted request has no response");

   assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> in_acc && req_tuser == MODE_BIT)
      else $error("nvram written without an accepted bit request");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule

/* dv/serial_rtc_nvram_counter_interface_test.sv */
// self-checking testbench for the serial rtc / nvram interface: serial transfers,
// power-down and interface resets checked bit by bit against a shadow of the chip
// depends on srtc_pkg and serial_rtc_nvram_counter_interface
import srtc_pkg::*;

class rtc_shadow;
   localparam int WR_BIT    = 7;
   localparam int UPPER_BIT = 6;
   localparam int CLOCK_BIT = 5;

   // control write bits and the status flags they acknowledge
   localparam logic [7:0] CTL_CLR_TICK  = 8'h04;
   localparam logic [7:0] CTL_CLR_ALARM = 8'h08;
   localparam logic [7:0] CTL_CLR_POWER = 8'h01;
   localparam logic [7:0] CTL_HALT      = 8'h40;
   localparam logic [7:0] STS_TICK      = 8'h10;
   localparam logic [7:0] STS_ALARM     = 8'h02;
   localparam logic [7:0] STS_POWER     = 8'h01;

   logic [4:0] phase;
   logic [7:0] addr_sr;
   logic [7:0] data_sr;
   logic [7:0] status_reg;
   logic [7:0] control_reg;
   logic [7:0] nvram [MEM_DEPTH];
   result_type expected_lines [$];
   int failures;

   function new();
      phase = '0;
      addr_sr = '0;
      data_sr = '0;
      status_reg = '0;
      control_reg = '0;
      failures = 0;
      foreach (nvram[i]) nvram[i] = '0;
   endfunction

   function logic [MEM_AW-1:0] slot(logic [7:0] a);
      return {a[UPPER_BIT], a[BANK_AW-1:0]};
   endfunction

   function void note_request(logic [1:0] mode, logic bit_in, logic [31:0] now);
      result_type r;
      logic wr;
      r = '0;
      if (mode == MODE_RESET) begin
         phase = '0;
         addr_sr = '0;
         data_sr = '0;
      end else if (mode == MODE_POWER) begin
         status_reg |= STATUS_PWR_DOWN;
      end else if (mode == MODE_BIT) begin
         r.data_out = bit_in;
         phase = phase + 5'd1;
         if (phase <= PHASE_ADDR_END) begin
            addr_sr = {addr_sr[6:0], bit_in};
         end else begin
            wr = addr_sr[WR_BIT];
            if (phase > PHASE_DATA_END) phase = PHASE_DATA_END;
            if (phase == PHASE_DATA_GO && !wr) begin
               if (addr_sr[CLOCK_BIT]) begin
                  case (addr_sr[6:0])
                     CLK_TIME3:   data_sr = now[31:24];
                     CLK_TIME2:   data_sr = now[23:16];
                     CLK_TIME1:   data_sr = now[15:8];
                     CLK_TIME0:   data_sr = now[7:0];
                     CLK_STATUS:  data_sr = status_reg | STATUS_READ_SET;
                     CLK_CONTROL: data_sr = control_reg & ~CONTROL_MASK;
                     default:     data_sr = '0;
                  endcase
               end else begin
                  data_sr = nvram[slot(addr_sr)];
               end
            end
            if (wr) data_sr = {data_sr[6:0], bit_in};
            else r.data_out = data_sr[PHASE_DATA_END - phase];
            if (phase == PHASE_DATA_END) begin
               if (wr && addr_sr[CLOCK_BIT]) begin
                  // only control takes writes; time, status and holes drop them
                  if (addr_sr[6:0] == CLK_CONTROL) begin
                     control_reg = data_sr;
                     if ((data_sr & CTL_CLR_TICK) != 0) status_reg &= ~STS_TICK;
                     if ((data_sr & CTL_CLR_ALARM) != 0) status_reg &= ~STS_ALARM;
                     if ((data_sr & CTL_CLR_POWER) != 0) status_reg &= ~STS_POWER;
                     r.halt_request = (data_sr & CTL_HALT) != 0;
                  end
               end else if (wr) begin
                  nvram[slot(addr_sr)] = data_sr;
               end
               // increment wraps within the half selected by the write bit
               addr_sr = {addr_sr[WR_BIT], addr_sr[6:0] + 7'd1};
               phase = phase - 5'd8;
            end
         end
      end
      expected_lines.push_back(r);
   endfunction

   function void check_response(logic [7:0] tdata);
      result_type r;
      if (expected_lines.size() == 0) begin
         $display("%0t: response %h with no request outstanding", $time, tdata);
         failures++;
      end else begin
         r = expected_lines.pop_front();
         if (tdata[0] !== r.data_out) begin
            $display("%0t: data_out expected %0d got %0d", $time, r.data_out, tdata[0]);
            failures++;
         end
         if (tdata[1] !== r.halt_request) begin
            $display("%0t: halt_request expected %0d got %0d", $time,
                     r.halt_request, tdata[1]);
            failures++;
         end
      end
   endfunction
endclass

module serial_rtc_nvram_counter_interface_test;
   import srtc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [6:0] HALF_TOP    = 7'h7F;
   localparam int ITEM_TARGET = 1100;
   localparam int PHASE_ITEMS = 275;
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // data_bit [0], time_now [32:1], zero fill
   logic [1:0]  req_tuser;   // mode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // data_out [0], halt_request [1], zero fill

   rtc_shadow sb;
   int sent_items;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;
   int idle_tab [4] = '{0, 46, 0, 27};
   int stall_tab [4] = '{0, 0, 46, 27};

   serial_rtc_nvram_counter_interface i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata[0], req_tdata[32:1]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

   // called and returns just after a falling edge; valid stays up for the next call
   task automatic send_request(input logic [1:0] mode, input logic bit_in);
      logic [31:0] now;
      case ($urandom_range(0, 7))
         0:       now = '0;
         1:       now = '1;
         default: now = $urandom;
      endcase
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now, bit_in};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (mode != MODE_UNUSED) sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] v);
      for (int i = 7; i >= 0; i--) send_request(MODE_BIT, v[i]);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.expected_lines.size() != 0);
   endtask

   initial begin
      logic [7:0] addr;
      logic [6:0] lo;
      logic       wr;
      int         cur_phase;
      int         pick;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      sent_items = 0;
      idle_pct = idle_tab[0];
      stall_pct = stall_tab[0];
      cur_phase = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // power-down, unused mode, then a control write that halts and acks everything
      send_request(MODE_POWER, 1'b1);
      send_request(MODE_UNUSED, 1'b1);
      send_request(MODE_RESET, 1'b0);
      send_byte({1'b1, CLK_CONTROL});
      send_byte(8'hFF);
      send_request(MODE_RESET, 1'b1);
      send_request(MODE_POWER, 1'b0);

      while (sent_items < ITEM_TARGET) begin
         if (sent_items / PHASE_ITEMS != cur_phase) begin
            cur_phase = sent_items / PHASE_ITEMS;
            idle_pct = idle_tab[cur_phase % 4];
            stall_pct = stall_tab[cur_phase % 4];
            wait_for_drain();
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            wr = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  addr = 8'($urandom);
                  addr[5] = 1'b0;
               end
               4, 5, 6: begin
                  case ($urandom_range(0, 6))
                     0, 1, 2, 3: lo = CLK_TIME3 + 7'($urandom_range(0, 3));
                     4:          lo = CLK_STATUS;
                     5:          lo = CLK_CONTROL;
                     default:    lo = {2'b01, 5'($urandom)};
                  endcase
                  addr = {wr, lo};
                  // now and then an unmapped clock address in the upper half
                  if ($urandom_range(0, 7) == 0) addr[6] = 1'b1;
               end
               7:       addr = 8'($urandom);
               8:       addr = {wr, HALF_TOP - 7'($urandom_range(0, 1))};
               default: addr = {1'b1, CLK_CONTROL};
            endcase
            send_request(MODE_RESET, 1'($urandom_range(0, 1)));
            send_byte(addr);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            // broken tail: stray bits left hanging in a half-shifted byte
            if (pick == 7) begin
               repeat ($urandom_range(1, 12)) send_request(MODE_BIT, 1'($urandom_range(0, 1)));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: send_request(MODE_BIT, 1'($urandom_range(0, 1)));
                  4, 5:       send_request(MODE_RESET, 1'($urandom_range(0, 1)));
                  6, 7, 8:    send_request(MODE_POWER, 1'($urandom_range(0, 1)));
                  default:    send_request(MODE_UNUSED, 1'($urandom_range(0, 1)));
               endcase
            end
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.expected_lines.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
